### rtl/hcbp_pkg.sv
// shared types and constants of the huffman code bit packer
package hcbp_pkg;

	localparam int BYTE_BITS = 8;

	// input item kinds
	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_FLUSH = 2'd2
	} kind_t;

	// one packed output result
	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] pad_bits;
		logic       is_final;
		logic       last_of_run;
	} res_t;

endpackage

### rtl/hcbp_front.sv
// front end: accepts items, writes and reads the code table, feeds the op queue
module hcbp_front #(
	parameter int SYMBOL_COUNT = 256,
	parameter int CODE_W       = 32,
	parameter int LEN_W        = 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [1:0]               kind,
	input  logic [7:0]               symbol,
	input  logic [31:0]              code_bits,
	input  logic [5:0]               code_len,
	output logic                     push,
	output logic [CODE_W+LEN_W:0]    push_data,
	input  logic                     q_full
);

	localparam int ADDR_W = $clog2(SYMBOL_COUNT);
	localparam int ENTRY_W = CODE_W + LEN_W;
	localparam logic [8:0] SYM_LIMIT = 9'(SYMBOL_COUNT);
	localparam logic [5:0] LEN_CAP = 6'(CODE_W);

	logic [ENTRY_W-1:0] table_mem [SYMBOL_COUNT];
	logic [ENTRY_W-1:0] rd_s1;
	logic               valid_s1;
	logic               flush_s1;

	logic               accept;
	logic               in_range;
	hcbp_pkg::kind_t    kind_c;
	logic [LEN_W-1:0]   len_w;
	logic [LEN_W-1:0]   shamt;
	logic [63:0]        wide;
	logic [ENTRY_W-1:0] wentry;

	assign kind_c   = hcbp_pkg::kind_t'(kind);
	assign accept   = s_tvalid && s_tready;
	assign in_range = {1'b0, symbol} < SYM_LIMIT;
	assign push     = valid_s1 && !q_full;
	assign s_tready = !valid_s1 || !q_full;
	assign push_data = {flush_s1, rd_s1};

	// saturate the length and store the code left aligned, upper bits dropped
	always_comb begin
		len_w  = (code_len > LEN_CAP) ? LEN_W'(CODE_W) : code_len[LEN_W-1:0];
		shamt  = LEN_W'(CODE_W) - len_w;
		wide   = {32'd0, code_bits} << shamt;
		wentry = {len_w, wide[CODE_W-1:0]};
	end

	// code table, written by in-range table writes, read into a register on every accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			if (kind_c == hcbp_pkg::KIND_WRITE && in_range) begin
				table_mem[symbol[ADDR_W-1:0]] <= wentry;
			end
			rd_s1 <= table_mem[symbol[ADDR_W-1:0]];
		end
	end

	// lookup stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			flush_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (kind_c == hcbp_pkg::KIND_DATA && in_range) ||
				(kind_c == hcbp_pkg::KIND_FLUSH);
			flush_s1 <= (kind_c == hcbp_pkg::KIND_FLUSH);
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

### rtl/hcbp_queue.sv
// two-entry op queue between the front end and the packer
module hcbp_queue #(
	parameter int DATA_W = 39
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              q_valid,
	output logic [DATA_W-1:0] q_data
);

	logic [DATA_W-1:0] slot_q [2];
	logic              wr_q;
	logic              rd_q;
	logic [1:0]        cnt_q;

	assign full    = cnt_q == 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign q_data  = slot_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("op queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("op queue read while empty");

endmodule

### rtl/hcbp_packer.sv
// back end: shifts code bits into the byte accumulator and emits bytes
module hcbp_packer #(
	parameter int CODE_W = 32,
	parameter int LEN_W  = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  logic [CODE_W+LEN_W:0] q_data,
	output logic                  pop,
	output hcbp_pkg::res_t        res,
	output logic                  res_valid,
	input  logic                  res_ready
);

	localparam logic [3:0] BYTE_N = 4'(hcbp_pkg::BYTE_BITS);

	logic                 busy_q;
	logic                 flush_q;
	logic [7:0]           acc_q;
	logic [2:0]           held_q;
	logic [LEN_W-1:0]     rem_q;
	logic [CODE_W-1:0]    aligned_q;
	hcbp_pkg::res_t       res_q;
	logic                 res_valid_q;

	logic [3:0]           room;
	logic                 emit;
	logic                 out_free;
	logic                 step_go;
	logic                 last;
	logic                 done;
	logic                 load;
	logic [LEN_W-1:0]     consumed;
	logic [15:0]          shifted;
	logic [LEN_W-1:0]     rem_n;
	logic [CODE_W-1:0]    aligned_n;
	logic [7:0]           tail_acc;
	logic [7:0]           flush_byte;

	assign res       = res_q;
	assign res_valid = res_valid_q;
	assign pop       = load;

	// one step of the current op
	always_comb begin
		room       = BYTE_N - {1'b0, held_q};
		out_free   = !res_valid_q || res_ready;
		emit       = flush_q ? (held_q != 3'd0) : (rem_q >= LEN_W'(room));
		consumed   = emit ? LEN_W'(room) : rem_q;
		shifted    = {acc_q, aligned_q[CODE_W-1 -: 8]} << consumed;
		rem_n      = rem_q - LEN_W'(room);
		aligned_n  = aligned_q << room;
		last       = rem_n < LEN_W'(BYTE_N);
		tail_acc   = aligned_n[CODE_W-1 -: 8] >> (BYTE_N - rem_n[3:0]);
		flush_byte = acc_q << room;
		step_go    = busy_q && (!emit || out_free);
		done       = step_go && (flush_q || !emit || last);
		load       = q_valid && (!busy_q || done);
	end

	// op registers and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			flush_q   <= 1'b0;
			acc_q     <= 8'd0;
			held_q    <= 3'd0;
			rem_q     <= '0;
			aligned_q <= '0;
		end else begin
			if (step_go) begin
				if (flush_q) begin
					acc_q  <= 8'd0;
					held_q <= 3'd0;
				end else if (!emit) begin
					acc_q  <= shifted[15:8];
					held_q <= held_q + rem_q[2:0];
				end else if (last) begin
					acc_q  <= tail_acc;
					held_q <= rem_n[2:0];
				end else begin
					acc_q     <= 8'd0;
					held_q    <= 3'd0;
					rem_q     <= rem_n;
					aligned_q <= aligned_n;
				end
			end
			if (load) begin
				busy_q    <= 1'b1;
				flush_q   <= q_data[CODE_W+LEN_W];
				rem_q     <= q_data[CODE_W+LEN_W-1 -: LEN_W];
				aligned_q <= q_data[CODE_W-1:0];
			end else if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step_go && emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && emit) begin
			if (flush_q) begin
				res_q <= '{out_byte: flush_byte, pad_bits: room[2:0],
					is_final: 1'b1, last_of_run: 1'b1};
			end else begin
				res_q <= '{out_byte: shifted[15:8], pad_bits: 3'd0,
					is_final: 1'b0, last_of_run: last};
			end
		end
	end

	a_final_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.is_final |-> res_q.last_of_run && res_q.pad_bits != 3'd0)
		else $error("flush byte without pad count or end of run");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step_go && flush_q |=> held_q == 3'd0 && acc_q == 8'd0)
		else $error("accumulator not cleared by flush");

endmodule

### rtl/huffman_code_bit_packer.sv
// top level of the huffman code bit packer
// Usage:
//   s_* carries input items: s_tuser is the kind (write table entry, encode
//   byte, flush), s_tdata the symbol, code word and code length. A table
//   write stores the code for one symbol; an encode item appends that
//   symbol's code, most significant bit first, to the byte accumulator; a
//   flush emits the partial byte left aligned with its pad count.
//   m_* carries one packed byte per transfer with its pad count in m_tdata;
//   m_tuser flags the padded flush byte, m_tlast marks the last byte that
//   one input item caused.
// An item passes the lookup register, the op queue, the packer op registers
//   and the output register before its first byte shows on m_tvalid.
// The op queue lets the front end take new items while the packer still works
//   on an earlier one. An encode or flush item yields at most 4 bytes for 32-bit
//   codes; table writes stay in the front end and never reach the packer.
// Reset clears the accumulator, queue and control; table entries are
//   undefined until written.
// When m_tready is low the output register holds, the packer stops, the
//   two-entry op queue fills and s_tready drops.
module huffman_code_bit_packer #(
	parameter int MAX_CODE_LEN = 32,
	parameter int SYMBOL_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // symbol[7:0], code_bits[39:8], code_len[45:40], zero
	input  logic [1:0]  s_tuser,   // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // out_byte[7:0], pad_bits[10:8], zero
	output logic        m_tuser,   // is_final
	output logic        m_tlast    // last_of_run
);

	localparam int CODE_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
	localparam int LEN_W  = $clog2(CODE_W + 1);
	localparam int OP_W   = CODE_W + LEN_W + 1;

	logic            push;
	logic [OP_W-1:0] push_data;
	logic            q_full;
	logic            pop;
	logic            q_valid;
	logic [OP_W-1:0] q_data;
	hcbp_pkg::res_t  res;

	// table and classification
	hcbp_front #(
		.SYMBOL_COUNT(SYMBOL_COUNT),
		.CODE_W(CODE_W),
		.LEN_W(LEN_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.kind(s_tuser),
		.symbol(s_tdata[7:0]),
		.code_bits(s_tdata[39:8]),
		.code_len(s_tdata[45:40]),
		.push(push),
		.push_data(push_data),
		.q_full(q_full)
	);

	// op queue
	hcbp_queue #(
		.DATA_W(OP_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(q_full),
		.pop(pop),
		.q_valid(q_valid),
		.q_data(q_data)
	);

	// bit packer
	hcbp_packer #(
		.CODE_W(CODE_W),
		.LEN_W(LEN_W)
	) u_packer (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_data(q_data),
		.pop(pop),
		.res(res),
		.res_valid(m_tvalid),
		.res_ready(m_tready)
	);

	// result fields onto the stream
	assign m_tdata = {5'd0, res.pad_bits, res.out_byte};
	assign m_tuser = res.is_final;
	assign m_tlast = res.last_of_run;

endmodule

### bench/tb.sv
// self-checking testbench of the huffman code bit packer
`timescale 1ns / 100ps

module tb;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int SYM_COUNT = 256;
	localparam int LEN_CAP = 32;
	localparam int RANDOM_ITEMS = 230;
	localparam int QUIET_ITEMS = 40;
	localparam int HOLD_AT_ITEM = 140;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 200000;

	// one stimulus row; n_typed < 0 means the predictor decides the bytes
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  sym;
		logic [31:0] bits;
		logic [5:0]  len;
		int          n_typed;
		logic [7:0]  t_byte;
		logic [2:0]  t_pad;
		logic        t_fin;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;    // symbol[7:0], code_bits[39:8], code_len[45:40], zero
	logic [1:0]  s_tuser = '0;    // kind[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;         // out_byte[7:0], pad_bits[10:8], zero
	logic        m_tuser;         // is_final
	logic        m_tlast;         // last_of_run

	// predictor state
	logic [31:0]    code_word [SYM_COUNT];
	int             code_length [SYM_COUNT];
	bit             entry_written [SYM_COUNT];
	logic [7:0]     written_syms [$];
	logic [7:0]     acc_bits;
	int             acc_count;
	hcbp_pkg::res_t expected_bytes [$];

	stim_row_t      stim_rows [$];
	int             mismatches = 0;
	int             counted_items = 0;
	int             cycles = 0;
	int unsigned    stall_left = 0;
	logic           quiet = 1'b0;
	logic           hold_long = 1'b0;
	hcbp_pkg::res_t want_res;
	hcbp_pkg::res_t got_res;

	huffman_code_bit_packer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	// predict the bytes one accepted item causes and queue them
	task automatic pack_code_bits(input logic [1:0] k, input logic [7:0] sym,
			input logic [31:0] bits, input logic [5:0] len);
		hcbp_pkg::res_t outs [4];
		int             cnt;
		int             n;
		int             pad;
		logic [31:0]    word;
		logic [7:0]     shifted;
		cnt = 0;
		if (k == hcbp_pkg::KIND_WRITE) begin
			n = (len > LEN_CAP) ? LEN_CAP : int'(len);
			word = (n < 32) ? (bits & ((32'd1 << n) - 32'd1)) : bits;
			code_word[sym] = word;
			code_length[sym] = n;
			if (!entry_written[sym]) begin
				entry_written[sym] = 1'b1;
				written_syms.push_back(sym);
			end
		end else if (k == hcbp_pkg::KIND_DATA) begin
			word = code_word[sym];
			n = code_length[sym];
			for (int i = n; i > 0; i--) begin
				acc_bits = {acc_bits[6:0], word[i-1]};
				acc_count++;
				if (acc_count == hcbp_pkg::BYTE_BITS) begin
					if (cnt < 4) outs[cnt] = {acc_bits, 3'd0, 1'b0, 1'b0};
					cnt++;
					acc_bits = '0;
					acc_count = 0;
				end
			end
		end else if (k == hcbp_pkg::KIND_FLUSH) begin
			if (acc_count > 0) begin
				pad = hcbp_pkg::BYTE_BITS - acc_count;
				shifted = acc_bits << pad;
				outs[0] = {shifted, 3'(pad), 1'b1, 1'b0};
				cnt = 1;
			end
			acc_bits = '0;
			acc_count = 0;
		end
		if (cnt > 4) cnt = 4;
		for (int i = 0; i < cnt; i++) begin
			if (i == cnt - 1) outs[i].last_of_run = 1'b1;
			expected_bytes.push_back(outs[i]);
		end
	endtask

	// offer one item, wait for the handshake, then predict it
	task automatic send_item(input stim_row_t row);
		int n0;
		hcbp_pkg::res_t r;
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, row.len, row.bits, row.sym};
		s_tuser <= row.kind;
		do @(posedge clk); while (!s_tready);
		n0 = expected_bytes.size();
		pack_code_bits(row.kind, row.sym, row.bits, row.len);
		// rows with bytes typed in replace the predicted ones
		if (row.n_typed >= 0) begin
			while (expected_bytes.size() > n0) void'(expected_bytes.pop_back());
			for (int i = 0; i < row.n_typed; i++) begin
				r = {row.t_byte, row.t_pad, row.t_fin, 1'b0};
				if (i == row.n_typed - 1) r.last_of_run = 1'b1;
				expected_bytes.push_back(r);
			end
		end
		if (row.kind != KIND_UNUSED) counted_items++;
		if (counted_items >= RANDOM_ITEMS + stim_rows.size() - QUIET_ITEMS) quiet <= 1'b1;
		// sender gap with junk on the bus
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= {$urandom, $urandom};
			s_tuser <= 2'($urandom);
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic add_row(input logic [1:0] k, input logic [7:0] sym,
			input logic [31:0] bits, input logic [5:0] len, input int n,
			input logic [7:0] b, input logic [2:0] pad, input logic fin);
		stim_rows.push_back({k, sym, bits, len, n, b, pad, fin});
	endtask

	// random item, mostly table writes of short codes and encodes of written symbols
	function automatic stim_row_t random_row();
		stim_row_t   row;
		int unsigned r;
		int unsigned rl;
		r = $urandom_range(0, 99);
		rl = $urandom_range(0, 99);
		row.bits = $urandom;
		row.len = 6'($urandom);
		row.sym = 8'($urandom);
		row.n_typed = -1;
		row.t_byte = '0;
		row.t_pad = '0;
		row.t_fin = 1'b0;
		if (r < 3) begin
			row.kind = KIND_UNUSED;
		end else if (r < 25 || written_syms.size() == 0) begin
			row.kind = hcbp_pkg::KIND_WRITE;
			if (rl < 5) row.len = 6'd0;
			else if (rl < 12) row.len = 6'($urandom_range(33, 63));
			else if (rl < 25) row.len = 6'($urandom_range(13, 32));
			else row.len = 6'($urandom_range(1, 12));
		end else if (r < 88) begin
			row.kind = hcbp_pkg::KIND_DATA;
			row.sym = written_syms[$urandom_range(0, written_syms.size() - 1)];
		end else begin
			row.kind = hcbp_pkg::KIND_FLUSH;
		end
		return row;
	endfunction

	// receiver side: short random stalls plus one long hold-off
	always @(posedge clk) begin
		if (stall_left > 0) stall_left--;
		else if (!quiet && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 3);
		m_tready <= arst_n && !hold_long && (stall_left == 0);
	end

	initial begin
		wait (counted_items >= HOLD_AT_ITEM);
		@(posedge clk);
		hold_long <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_long <= 1'b0;
	end

	// compare every accepted byte with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_res = {m_tdata[7:0], m_tdata[10:8], m_tuser, m_tlast};
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected byte: byte %h pad %0d final %b last %b",
						got_res.out_byte, got_res.pad_bits, got_res.is_final,
						got_res.last_of_run);
			end else begin
				want_res = expected_bytes.pop_front();
				if (got_res.out_byte !== want_res.out_byte ||
						got_res.pad_bits !== want_res.pad_bits ||
						got_res.is_final !== want_res.is_final ||
						got_res.last_of_run !== want_res.last_of_run) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want %h/%0d/%b/%b got %h/%0d/%b/%b",
							want_res.out_byte, want_res.pad_bits, want_res.is_final,
							want_res.last_of_run, got_res.out_byte, got_res.pad_bits,
							got_res.is_final, got_res.last_of_run);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[huffman_code_bit_packer] ERROR");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < SYM_COUNT; i++) begin
			code_word[i] = '0;
			code_length[i] = 0;
			entry_written[i] = 1'b0;
		end
		acc_bits = '0;
		acc_count = 0;

		// directed rows: flush and unused kind after reset, length cap,
		// dropped high code bits, zero length, padded flush, empty flush
		add_row(hcbp_pkg::KIND_FLUSH, 8'd0, 32'hDEAD_BEEF, 6'h3F, 0, 8'h00, 3'd0, 1'b0);
		add_row(KIND_UNUSED, 8'd7, 32'hFFFF_FFFF, 6'd5, 0, 8'h00, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_WRITE, 8'd0, 32'hFFFF_FFFF, 6'd8, 0, 8'h00, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_DATA, 8'd0, 32'h1234_5678, 6'h2A, 1, 8'hFF, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_WRITE, 8'd255, 32'hFFFF_FFFF, 6'd63, 0, 8'h00, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_DATA, 8'd255, 32'h0, 6'd0, 4, 8'hFF, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_WRITE, 8'd1, 32'hFFFF_FFFE, 6'd1, 0, 8'h00, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_WRITE, 8'd2, 32'h0000_0001, 6'd1, 0, 8'h00, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_DATA, 8'd2, 32'hFFFF_FFFF, 6'h3F, 0, 8'h00, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_FLUSH, 8'hFF, 32'h0, 6'd0, 1, 8'h80, 3'd7, 1'b1);
		add_row(hcbp_pkg::KIND_FLUSH, 8'h55, 32'hAAAA_5555, 6'h15, 0, 8'h00, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_WRITE, 8'd3, 32'h0000_00A5, 6'd0, 0, 8'h00, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_DATA, 8'd3, 32'h0, 6'd0, 0, 8'h00, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_WRITE, 8'd4, 32'hFFFF_FFFD, 6'd3, -1, 8'h00, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_DATA, 8'd4, 32'h0, 6'd0, -1, 8'h00, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_DATA, 8'd255, 32'h0, 6'd0, -1, 8'h00, 3'd0, 1'b0);
		add_row(KIND_UNUSED, 8'd4, 32'h0, 6'd0, 0, 8'h00, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_FLUSH, 8'd0, 32'h0, 6'd0, -1, 8'h00, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_WRITE, 8'd5, 32'h0000_0000, 6'd32, 0, 8'h00, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_DATA, 8'd5, 32'hFFFF_FFFF, 6'h3F, 4, 8'h00, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_DATA, 8'd4, 32'h0, 6'd0, -1, 8'h00, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_DATA, 8'd4, 32'h0, 6'd0, -1, 8'h00, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_DATA, 8'd1, 32'h0, 6'd0, -1, 8'h00, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_FLUSH, 8'd0, 32'h0, 6'd0, -1, 8'h00, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_WRITE, 8'd6, 32'h8000_0001, 6'd31, -1, 8'h00, 3'd0, 1'b0);
		add_row(hcbp_pkg::KIND_DATA, 8'd6, 32'h0, 6'd0, -1, 8'h00, 3'd0, 1'b0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) send_item(stim_rows[i]);
		while (counted_items < stim_rows.size() + RANDOM_ITEMS) send_item(random_row());
		s_tvalid <= 1'b0;

		// drain, then give late bytes a chance to show up
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_bytes.size() == 0) begin
			$display("[huffman_code_bit_packer] OK");
		end else begin
			$display("[huffman_code_bit_packer] ERROR");
		end
		$finish;
	end

endmodule
